### design/cddu_pkg.sv
// Shared types, constants and calendar tables for the calendar date difference unit.
`default_nettype none

package cddu_pkg;

    // Highest year that counts as a real calendar date.
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // Division by 100 of a 14-bit value: floor(y * 5243 / 2^19) is exact up to 16383.
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int DIV100_SHIFT = 19;

    // Division by 7 of a 15-bit value: floor(f * 37450 / 2^18) is exact up to 32767.
    localparam logic [15:0] DIV7_RECIP = 16'd37450;
    localparam int DIV7_SHIFT = 18;

    typedef struct packed {
        logic [4:0]  a_day;
        logic [3:0]  a_month;
        logic [13:0] a_year;
        logic [4:0]  b_day;
        logic [3:0]  b_month;
        logic [13:0] b_year;
    } cddu_in_t;

    typedef struct packed {
        logic signed [22:0] days_between;
        logic [13:0]        whole_years;
        logic               a_valid;
        logic               b_valid;
        logic [2:0]         a_weekday;
    } cddu_out_t;

    // Datapath operations, one per controller step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_AY,
        OP_DIV_PA,
        OP_DIV_BY,
        OP_DIV_PB,
        OP_MUL_A,
        OP_SUM_A,
        OP_MUL_B,
        OP_SUM_B,
        OP_WSUM,
        OP_WMUL,
        OP_FINISH
    } cddu_op_t;

    typedef struct packed {
        cddu_op_t op;
    } cddu_cmd_t;

    // Days in each month of a common year.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of each month in a common year.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] st;
        unique case (m)
            4'd1:    st = 9'd0;
            4'd2:    st = 9'd31;
            4'd3:    st = 9'd59;
            4'd4:    st = 9'd90;
            4'd5:    st = 9'd120;
            4'd6:    st = 9'd151;
            4'd7:    st = 9'd181;
            4'd8:    st = 9'd212;
            4'd9:    st = 9'd243;
            4'd10:   st = 9'd273;
            4'd11:   st = 9'd304;
            4'd12:   st = 9'd334;
            default: st = 9'd0;
        endcase
        return st;
    endfunction

    // The month term floor(3 * (m + 1) / 5) of the weekday formula, with
    // January and February counted as months 13 and 14.
    function automatic logic [3:0] month_term(input logic [3:0] cm);
        logic [3:0] t;
        unique case (cm)
            4'd3:          t = 4'd2;
            4'd4, 4'd5:    t = 4'd3;
            4'd6, 4'd7:    t = 4'd4;
            4'd8:          t = 4'd5;
            4'd9, 4'd10:   t = 4'd6;
            4'd11, 4'd12:  t = 4'd7;
            4'd13:         t = 4'd8;
            4'd14:         t = 4'd9;
            default:       t = 4'd0;
        endcase
        return t;
    endfunction

    // True when the fields name a real date.
    function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
                                     input logic [13:0] y, input logic leap);
        logic [4:0] lim;
        lim = month_len(m);
        if (m == 4'd2 && leap) begin
            lim = 5'd29;
        end
        return (y != 14'd0) && (y <= YEAR_MAX) && (m >= 4'd1) && (m <= 4'd12)
            && (d != 5'd0) && (d <= lim);
    endfunction

endpackage

`default_nettype wire

### design/calendar_date_difference_unit.sv
// Top level of the calendar date difference unit: controller and datapath.
// The finishing step writes the result register once the result side is free.
// One item at a time: date_stall stays high through the eleven datapath steps after an accept.
// The step sequence is the same whatever the two dates; only the finishing step waits on res_stall.
// A new item is accepted while the previous result still waits in the output register.
// Reset (rst_n low, asynchronous) empties the controller and drops the result valid flag.
`default_nettype none

module calendar_date_difference_unit import cddu_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     date_valid,
    output logic          date_stall,
    input  wire cddu_in_t date,
    output logic          res_valid,
    input  wire logic     res_stall,
    output cddu_out_t     res
);

    // The controller walks a fixed sequence of datapath operations for each item:
    // four divisions by 100 (year and year minus one, for each date), then for each
    // date a multiply by 365 and a sum that forms the serial day number and the
    // validity flag, then the weekday sum and its division by 7. The last step
    // forms every result field and writes the output register in one go.
    cddu_cmd_t cmd;

    cddu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .date_valid (date_valid),
        .date_stall (date_stall),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .cmd        (cmd)
    );

    // The datapath holds the accepted item, all intermediate values and the result
    // register; it has no control state of its own, so it needs no reset.
    cddu_datapath u_datapath (
        .clk  (clk),
        .cmd  (cmd),
        .date (date),
        .res  (res)
    );

endmodule

`default_nettype wire

### design/cddu_ctrl.sv
// Sequencing controller and handshake control for the calendar date difference unit.
`default_nettype none

module cddu_ctrl import cddu_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic date_valid,
    output logic      date_stall,
    output logic      res_valid,
    input  wire logic res_stall,
    output cddu_cmd_t cmd
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_DIV_AY = 12'b0000_0000_0010,
        ST_DIV_PA = 12'b0000_0000_0100,
        ST_DIV_BY = 12'b0000_0000_1000,
        ST_DIV_PB = 12'b0000_0001_0000,
        ST_MUL_A  = 12'b0000_0010_0000,
        ST_SUM_A  = 12'b0000_0100_0000,
        ST_MUL_B  = 12'b0000_1000_0000,
        ST_SUM_B  = 12'b0001_0000_0000,
        ST_WSUM   = 12'b0010_0000_0000,
        ST_WMUL   = 12'b0100_0000_0000,
        ST_FINISH = 12'b1000_0000_0000
    } cddu_state_t;

    cddu_state_t state_reg, state_next;
    logic        res_valid_reg, res_valid_next;
    logic        slot_free;

    assign slot_free  = !res_valid_reg || !res_stall;
    assign date_stall = (state_reg != ST_IDLE);
    assign res_valid  = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (date_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DIV_AY;
                end
            end
            ST_DIV_AY:
            begin
                cmd.op     = OP_DIV_AY;
                state_next = ST_DIV_PA;
            end
            ST_DIV_PA:
            begin
                cmd.op     = OP_DIV_PA;
                state_next = ST_DIV_BY;
            end
            ST_DIV_BY:
            begin
                cmd.op     = OP_DIV_BY;
                state_next = ST_DIV_PB;
            end
            ST_DIV_PB:
            begin
                cmd.op     = OP_DIV_PB;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.op     = OP_MUL_A;
                state_next = ST_SUM_A;
            end
            ST_SUM_A:
            begin
                cmd.op     = OP_SUM_A;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.op     = OP_MUL_B;
                state_next = ST_SUM_B;
            end
            ST_SUM_B:
            begin
                cmd.op     = OP_SUM_B;
                state_next = ST_WSUM;
            end
            ST_WSUM:
            begin
                cmd.op     = OP_WSUM;
                state_next = ST_WMUL;
            end
            ST_WMUL:
            begin
                cmd.op     = OP_WMUL;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (state_reg == ST_FINISH && slot_free)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (date_valid && !date_stall) |=> (state_reg == ST_DIV_AY))
        else $error("accepted item did not start the sequence");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result became valid outside the finishing step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && res_valid_reg && res_stall) |=> (state_reg == ST_FINISH))
        else $error("finishing step left while the result slot was full");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && slot_free) |=> (res_valid_reg && state_reg == ST_IDLE))
        else $error("finished item not placed in the result register");

endmodule

`default_nettype wire

### design/cddu_datapath.sv
// Arithmetic datapath of the calendar date difference unit: year divisions, serial days, weekday.
`default_nettype none

module cddu_datapath import cddu_pkg::*; (
    input  wire logic      clk,
    input  wire cddu_cmd_t cmd,
    input  wire cddu_in_t  date,
    output cddu_out_t      res
);

    cddu_in_t    item_reg;
    logic [7:0]  qay_reg, qpa_reg, qby_reg, qpb_reg;
    logic [21:0] m365_reg;
    logic [21:0] ser_a_reg, ser_b_reg;
    logic        av_reg, bv_reg;
    logic [14:0] f_reg;
    logic [12:0] q7_reg;
    cddu_out_t   res_reg;

    logic [13:0] pa, pb;
    assign pa = item_reg.a_year - 14'd1;
    assign pb = item_reg.b_year - 14'd1;

    // Shared divide-by-100 unit.
    logic [13:0] div_y;
    logic [26:0] div_prod;
    logic [7:0]  div_q;

    always_comb
    begin
        case (cmd.op)
            OP_DIV_AY: div_y = item_reg.a_year;
            OP_DIV_PA: div_y = pa;
            OP_DIV_BY: div_y = item_reg.b_year;
            default:   div_y = pb;
        endcase
    end

    assign div_prod = 27'(div_y) * 27'(DIV100_RECIP);
    assign div_q    = div_prod[26:DIV100_SHIFT];

    // Leap years: divisible by 4, and not a century unless the century count is a multiple of 4.
    logic [14:0] hund_a, hund_b;
    logic        leap_a, leap_b;
    assign hund_a = 15'(qay_reg) * 15'd100;
    assign hund_b = 15'(qby_reg) * 15'd100;
    assign leap_a = (item_reg.a_year[1:0] == 2'b00)
                 && ((15'(item_reg.a_year) != hund_a) || (qay_reg[1:0] == 2'b00));
    assign leap_b = (item_reg.b_year[1:0] == 2'b00)
                 && ((15'(item_reg.b_year) != hund_b) || (qby_reg[1:0] == 2'b00));

    // 365 times the count of full years before the date.
    logic [13:0] mul_p;
    logic [22:0] m365_prod;
    assign mul_p     = (cmd.op == OP_MUL_B) ? pb : pa;
    assign m365_prod = 23'(mul_p) * 23'd365;

    // Serial day number from the registered product and the leap-day corrections.
    logic        sum_b;
    logic [13:0] sum_p;
    logic [7:0]  sum_q;
    logic [3:0]  sum_m;
    logic [4:0]  sum_d;
    logic        sum_leap;
    logic [21:0] ser;

    assign sum_b    = (cmd.op == OP_SUM_B);
    assign sum_p    = sum_b ? pb : pa;
    assign sum_q    = sum_b ? qpb_reg : qpa_reg;
    assign sum_m    = sum_b ? item_reg.b_month : item_reg.a_month;
    assign sum_d    = sum_b ? item_reg.b_day : item_reg.a_day;
    assign sum_leap = sum_b ? leap_b : leap_a;

    assign ser = m365_reg + 22'(sum_p >> 2) - 22'(sum_q) + 22'(sum_q >> 2)
               + 22'(month_start(sum_m)) + 22'((sum_m > 4'd2) && sum_leap) + 22'(sum_d);

    // Weekday sum; January and February belong to the previous year.
    logic [3:0]  cm;
    logic [13:0] cy;
    logic [7:0]  qcy;
    logic [14:0] f_sum;

    always_comb
    begin
        if (item_reg.a_month == 4'd1)
        begin
            cm  = 4'd13;
            cy  = pa;
            qcy = qpa_reg;
        end
        else if (item_reg.a_month == 4'd2)
        begin
            cm  = 4'd14;
            cy  = pa;
            qcy = qpa_reg;
        end
        else
        begin
            cm  = item_reg.a_month;
            cy  = item_reg.a_year;
            qcy = qay_reg;
        end
    end

    assign f_sum = 15'(item_reg.a_day) + 15'({cm, 1'b0}) + 15'(month_term(cm)) + 15'(cy)
                 + 15'(cy >> 2) - 15'(qcy) + 15'(qcy >> 2) + 15'd1;

    logic [30:0] f_prod;
    assign f_prod = 31'(f_reg) * 31'(DIV7_RECIP);

    // Final result fields.
    logic [14:0] wd_rem;
    logic        a_after;
    logic        a_first;
    logic [3:0]  lo_m, hi_m;
    logic [4:0]  lo_d, hi_d;
    logic [13:0] yr_diff;
    logic [13:0] years;
    cddu_out_t   res_next;

    assign wd_rem  = f_reg - ((15'(q7_reg) << 3) - 15'(q7_reg));
    assign a_after = {item_reg.a_year, item_reg.a_month, item_reg.a_day}
                   > {item_reg.b_year, item_reg.b_month, item_reg.b_day};
    assign a_first = item_reg.a_year < item_reg.b_year;
    assign lo_m    = a_first ? item_reg.a_month : item_reg.b_month;
    assign lo_d    = a_first ? item_reg.a_day : item_reg.b_day;
    assign hi_m    = a_first ? item_reg.b_month : item_reg.a_month;
    assign hi_d    = a_first ? item_reg.b_day : item_reg.a_day;
    assign yr_diff = a_first ? (item_reg.b_year - item_reg.a_year)
                             : (item_reg.a_year - item_reg.b_year);

    always_comb
    begin
        years = 14'd0;
        if (item_reg.a_year != item_reg.b_year)
        begin
            years = yr_diff;
            if ((hi_m < lo_m) || ((hi_m == lo_m) && (hi_d < lo_d)))
            begin
                years = yr_diff - 14'd1;
            end
        end
    end

    always_comb
    begin
        res_next.days_between = '0;
        if (av_reg && bv_reg)
        begin
            if (a_after)
            begin
                res_next.days_between = '1;
            end
            else
            begin
                res_next.days_between = 23'(ser_b_reg) - 23'(ser_a_reg);
            end
        end
        res_next.whole_years = years;
        res_next.a_valid     = av_reg;
        res_next.b_valid     = bv_reg;
        res_next.a_weekday   = av_reg ? wd_rem[2:0] : 3'd0;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:   item_reg <= date;
            OP_DIV_AY: qay_reg <= div_q;
            OP_DIV_PA: qpa_reg <= div_q;
            OP_DIV_BY: qby_reg <= div_q;
            OP_DIV_PB: qpb_reg <= div_q;
            OP_MUL_A, OP_MUL_B: m365_reg <= m365_prod[21:0];
            OP_SUM_A:
            begin
                ser_a_reg <= ser;
                av_reg    <= date_ok(item_reg.a_day, item_reg.a_month, item_reg.a_year, leap_a);
            end
            OP_SUM_B:
            begin
                ser_b_reg <= ser;
                bv_reg    <= date_ok(item_reg.b_day, item_reg.b_month, item_reg.b_year, leap_b);
            end
            OP_WSUM:   f_reg <= f_sum;
            OP_WMUL:   q7_reg <= f_prod[30:DIV7_SHIFT];
            OP_FINISH: res_reg <= res_next;
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

endmodule

`default_nettype wire
